// ===== src/udig_pkg.sv =====
package udig_pkg;

	localparam int MAX_OUT_POINTS = 64;
	localparam int INDEX_BITS     = 16;
	localparam int MAXP_BITS      = 7;
	localparam int CNT_BITS       = $clog2(MAX_OUT_POINTS + 1);
	localparam int SPAN_BITS      = $clog2(MAX_OUT_POINTS);
	localparam int STEP_BITS      = $clog2(INDEX_BITS);

	localparam logic [MAXP_BITS-1:0] MAXP_RESET = MAXP_BITS'(MAX_OUT_POINTS);

	typedef struct packed {
		logic load;
		logic div_step;
		logic emit_adv;
	} ctrl_cmd_t;

	typedef struct packed {
		logic none;
		logic direct;
		logic div_done;
		logic last;
	} dp_status_t;

endpackage

// ===== src/uniform_downsample_index_gen_top.sv =====
// Uniform downsample index generator. Each input beat carries a history
// length L; the block answers with up to max_points ascending indices of
// points to keep, the final one flagged by last_index. L or max_points zero
// gives no output. L <= max_points gives 0..L-1, a max_points of one gives
// the single index 0, and otherwise index i is round(i*(L-1)/(max_points-1))
// rounded half up. max_points above 64 acts as 64 and resets to 64. One
// request is handled at a time: the input is stalled from acceptance until
// the last index beat is taken. When downsampling, a serial divider first
// divides L-1 by max_points-1, then indices are produced by accumulation
// at one beat per cycle while out_stall is low; when every index is kept,
// or max_points is one, the divide is skipped, and a request with no output
// goes straight back to idle without stalling the input.
module uniform_downsample_index_gen_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [udig_pkg::MAXP_BITS-1:0]   cfg_wr_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [udig_pkg::INDEX_BITS-1:0]  history_length,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [udig_pkg::INDEX_BITS-1:0]  point_index,
	output logic                             last_index
);
	import udig_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	udig_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	udig_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.history_length (history_length),
		.cmd            (cmd),
		.status         (status),
		.point_index    (point_index),
		.last_index     (last_index)
	);

	a_busy_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while output beat pending");

	a_last_ends_request: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_index) |=> !out_valid)
		else $error("output continues after last beat");

	a_zero_length_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && history_length == '0) |=> !out_valid)
		else $error("output for zero length request");

endmodule

// ===== src/udig_ctrl.sv =====
module udig_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  logic                   out_stall,
	input  udig_pkg::dp_status_t   status,
	output udig_pkg::ctrl_cmd_t    cmd
);
	import udig_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d      = state_q;
		in_stall     = 1'b1;
		out_valid    = 1'b0;
		cmd.load     = 1'b0;
		cmd.div_step = 1'b0;
		cmd.emit_adv = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (status.none) begin
						state_d = ST_IDLE;
					end else if (status.direct) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					cmd.emit_adv = 1'b1;
					if (status.last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/udig_datapath.sv =====
module udig_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [udig_pkg::MAXP_BITS-1:0]      cfg_wr_data,
	input  logic [udig_pkg::INDEX_BITS-1:0]     history_length,
	input  udig_pkg::ctrl_cmd_t                 cmd,
	output udig_pkg::dp_status_t                status,
	output logic [udig_pkg::INDEX_BITS-1:0]     point_index,
	output logic                                last_index
);
	import udig_pkg::*;

	logic [MAXP_BITS-1:0]  max_points_q;
	logic [CNT_BITS-1:0]   m_eff;
	logic [SPAN_BITS-1:0]  span_in;
	logic                  len_fits;
	logic                  m_is_one;

	logic                  direct_q;
	logic [SPAN_BITS-1:0]  span_q;
	logic [CNT_BITS-1:0]   n_q;
	logic [CNT_BITS-1:0]   k_q;
	logic [STEP_BITS-1:0]  step_q;
	logic [INDEX_BITS-1:0] dvd_q;
	logic [SPAN_BITS-1:0]  rem_q;
	logic [INDEX_BITS-1:0] acc_q;
	logic [SPAN_BITS-1:0]  frac_q;

	logic [SPAN_BITS:0]    trial;
	logic                  trial_ge;
	logic [SPAN_BITS:0]    frac_sum;
	logic                  frac_wrap;
	logic [CNT_BITS-1:0]   k_next;

	always_comb begin
		if (max_points_q > MAXP_BITS'(MAX_OUT_POINTS)) begin
			m_eff = CNT_BITS'(MAX_OUT_POINTS);
		end else begin
			m_eff = CNT_BITS'(max_points_q);
		end
		span_in  = SPAN_BITS'(m_eff - CNT_BITS'(1));
		len_fits = history_length <= INDEX_BITS'(m_eff);
		m_is_one = m_eff == CNT_BITS'(1);

		status.none     = (history_length == '0) || (m_eff == '0);
		status.direct   = len_fits || m_is_one;
		status.div_done = step_q == STEP_BITS'(INDEX_BITS - 1);

		k_next      = k_q + CNT_BITS'(1);
		status.last = k_next == n_q;

		trial    = {rem_q, dvd_q[INDEX_BITS-1]};
		trial_ge = trial >= {1'b0, span_q};

		frac_sum  = {1'b0, frac_q} + {1'b0, rem_q};
		frac_wrap = frac_sum >= {1'b0, span_q};

		point_index = direct_q ? INDEX_BITS'(k_q) : acc_q;
		last_index  = status.last;
	end

	// register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_points_q <= MAXP_RESET;
		end else if (cfg_wr_en) begin
			max_points_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			direct_q <= len_fits || m_is_one;
			span_q   <= span_in;
			k_q      <= '0;
			step_q   <= '0;
			dvd_q    <= history_length - INDEX_BITS'(1);
			rem_q    <= '0;
			acc_q    <= '0;
			frac_q   <= span_in >> 1;
			if (len_fits) begin
				n_q <= CNT_BITS'(history_length);
			end else if (m_is_one) begin
				n_q <= CNT_BITS'(1);
			end else begin
				n_q <= m_eff;
			end
		end else if (cmd.div_step) begin
			// restoring divide, one quotient bit per cycle
			step_q <= step_q + STEP_BITS'(1);
			dvd_q  <= {dvd_q[INDEX_BITS-2:0], trial_ge};
			if (trial_ge) begin
				rem_q <= SPAN_BITS'(trial - {1'b0, span_q});
			end else begin
				rem_q <= SPAN_BITS'(trial);
			end
		end else if (cmd.emit_adv) begin
			k_q <= k_next;
			// quotient in dvd_q, remainder in rem_q
			if (frac_wrap) begin
				acc_q  <= acc_q + dvd_q + INDEX_BITS'(1);
				frac_q <= SPAN_BITS'(frac_sum - {1'b0, span_q});
			end else begin
				acc_q  <= acc_q + dvd_q;
				frac_q <= SPAN_BITS'(frac_sum);
			end
		end
	end

endmodule

// ===== tb/sv/tb_uniform_downsample_index_gen_top.sv =====
module tb_uniform_downsample_index_gen_top;
	timeunit 1ns;
	timeprecision 1ps;

	import udig_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [MAXP_BITS-1:0]   cfg_wr_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [INDEX_BITS-1:0]  history_length = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [INDEX_BITS-1:0]  point_index;
	logic                   last_index;

	logic [INDEX_BITS-1:0]  pending_len[$];
	logic [INDEX_BITS-1:0]  want_index[$];
	logic                   want_last[$];
	int unsigned            max_pts = MAX_OUT_POINTS;
	int unsigned            lens_sent = 0;
	int unsigned            lens_taken = 0;
	int unsigned            errors = 0;
	int unsigned            hold_cycles = 0;
	logic                   gaps_on = 1'b1;

	uniform_downsample_index_gen_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.history_length (history_length),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.point_index    (point_index),
		.last_index     (last_index)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int unsigned eff_max();
		return (max_pts > MAX_OUT_POINTS) ? MAX_OUT_POINTS : max_pts;
	endfunction

	// queue the indices a request of this length should produce
	function automatic void expect_kept_points(input logic [INDEX_BITS-1:0] len);
		int unsigned m;
		int unsigned n;
		longint unsigned span;
		longint unsigned idx;
		m = eff_max();
		if (len == 0 || m == 0)
			return;
		if (len <= m) begin
			n = len;
			for (int unsigned k = 0; k < n; k++) begin
				want_index.push_back(INDEX_BITS'(k));
				want_last.push_back(k + 1 == n);
			end
		end else if (m == 1) begin
			want_index.push_back('0);
			want_last.push_back(1'b1);
		end else begin
			span = m - 1;
			for (int unsigned k = 0; k < m; k++) begin
				idx = (longint'(k) * (longint'(len) - 1) + span / 2) / span;
				want_index.push_back(INDEX_BITS'(idx));
				want_last.push_back(k + 1 == m);
			end
		end
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (errors < 100)
			$display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
		errors++;
	endtask

	// sender
	always @(posedge clk) begin
		logic take;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && in_stall)) begin
			take = (pending_len.size() != 0) && !(gaps_on && $urandom_range(99) < 6);
			if (take) begin
				history_length <= pending_len.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver, with a counted hold-off
	always @(posedge clk) begin
		if (hold_cycles != 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= gaps_on && ($urandom_range(99) < 6);
		end
	end

	// check result beats first, then predict from the accepted request beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (want_index.size() == 0) begin
					report_mismatch("unexpected beat, point_index", point_index, -1);
				end else begin
					if (point_index !== want_index[0])
						report_mismatch("point_index", point_index, want_index[0]);
					if (last_index !== want_last[0])
						report_mismatch("last_index", last_index, want_last[0]);
					void'(want_index.pop_front());
					void'(want_last.pop_front());
				end
			end
			if (in_valid && !in_stall) begin
				expect_kept_points(history_length);
				lens_taken++;
			end
		end
	end

	task automatic send(input logic [INDEX_BITS-1:0] len);
		pending_len.push_back(len);
		lens_sent++;
	endtask

	task automatic settle();
		while (lens_taken != lens_sent || want_index.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic set_max(input int unsigned v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= MAXP_BITS'(v);
		max_pts = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [INDEX_BITS-1:0] pick_length();
		int unsigned m;
		int unsigned r;
		m = eff_max();
		r = $urandom_range(99);
		if (r < 35)
			return INDEX_BITS'($urandom_range(m + 3, 0));
		if (r < 75)
			return INDEX_BITS'($urandom());
		if (r < 88)
			return INDEX_BITS'($urandom_range(16'hFFFF, 16'hFF00));
		return INDEX_BITS'($urandom_range(300, m));
	endfunction

	function automatic int unsigned pick_max();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 5)
			return 0;
		if (r < 10)
			return 1;
		if (r < 20)
			return MAX_OUT_POINTS;
		if (r < 27)
			return $urandom_range(127, MAX_OUT_POINTS + 1);
		return $urandom_range(MAX_OUT_POINTS, 2);
	endfunction

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset maximum of 64
		send(0); send(1); send(2); send(63); send(64); send(65); send(16'hFFFF);
		settle();
		// maximum of one
		set_max(1);
		send(1); send(2); send(16'hFFFF);
		settle();
		// maximum of zero
		set_max(0);
		send(0); send(7);
		settle();
		// saturating maximum
		set_max(127);
		send(64); send(65); send(16'hFFFF);
		settle();
		set_max(2);
		send(2); send(3); send(16'hFFFF);
		settle();
		set_max(3);
		send(3); send(4); send(40000);
		settle();

		for (int p = 0; p < 10; p++) begin
			set_max(p == 0 ? MAX_OUT_POINTS : pick_max());
			gaps_on <= (p != 3);
			if (p == 5) begin
				if (eff_max() == 0)
					set_max(MAX_OUT_POINTS);
				@(posedge clk);
				hold_cycles <= 600;
				send(16'hFFFF);
			end
			for (int i = 0; i < 39; i++)
				send(pick_length());
			settle();
		end
		gaps_on <= 1'b1;

		if (errors == 0) begin
			$display("PASS uniform_downsample_index_gen_top");
		end else begin
			$display("FAIL uniform_downsample_index_gen_top");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("timeout at %0t", $time);
		$display("FAIL uniform_downsample_index_gen_top");
		$finish;
	end

endmodule
